FILE: src/bdre_pkg.sv
`default_nettype none
package bdre_pkg;

   // Width of the configuration register.
   localparam int CSR_WIDTH = 6;

   // Pending counts travel between the parts at the width of the largest build.
   localparam int PEND_CNT_WIDTH = 8;

   // Width of the run offset on the result channel.
   localparam int OFFSET_WIDTH = 32;

   // Result kinds.
   localparam logic KIND_DATA  = 1'b0;
   localparam logic KIND_CLOSE = 1'b1;

   // One command from the classifier to the emitter.
   typedef struct packed {
      logic                      close_first;
      logic                      emit_mod;
      logic                      close_last;
      logic [PEND_CNT_WIDTH-1:0] flush_cnt;
      logic [7:0]                mod_byte;
      logic [OFFSET_WIDTH-1:0]   run_offset;
   } bdre_cmd_type;

endpackage
`default_nettype wire

FILE: src/byte_diff_run_extractor_unit.sv
`default_nettype none
// Byte diff run extractor.
// The req channel carries one byte pair per beat: the original byte, the modified
// byte, a flag telling whether the original stream still has a byte at this address,
// and an end-of-stream flag on the final modified byte. The rsp channel returns the
// differing runs: data beats carry a modified byte with the run's start address, a
// close beat (kind 1) ends each run, and last marks the final beat caused by one req.
// The csr channel writes the compare size; it is taken at any time and is meant to be
// written while the block is idle.
// The command for a req passes through the command queue and the emitter's sequencer
// state before the rsp output register raises rsp_valid. The emitter takes each command
// from the queue while idle and then sends its beats; reqs that cause no beat are not
// queued. A req that releases held matching bytes streams them one per cycle from the
// pending RAM while rsp is not stalled, and further reqs wait until that flush has left
// the RAM, since the next matching bytes reuse its entries.
// A two-entry command queue and the rsp output register let req keep flowing while
// rsp stalls; when both fill, req_ready drops and nothing is lost.
// Reset clears the address counter, the run state and the queue, and sets the
// compare size to one. The pending RAM needs no clearing.
module byte_diff_run_extractor_unit #(
   parameter int MAX_COMPARE = 32,
   parameter int ADDR_WIDTH  = 32
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [bdre_pkg::CSR_WIDTH-1:0]    csr_data,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [7:0]                        req_original_byte,
   input  wire logic [7:0]                        req_modified_byte,
   input  wire logic                              req_original_present,
   input  wire logic                              req_end_of_stream,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic                                   rsp_kind,
   output logic      [bdre_pkg::OFFSET_WIDTH-1:0] rsp_run_offset,
   output logic      [7:0]                        rsp_data_byte,
   output logic                                   rsp_last
);
   import bdre_pkg::*;

   localparam int CNT_WIDTH = (MAX_COMPARE > 1) ? $clog2(MAX_COMPARE) : 1;

   logic                 queue_full;
   logic                 queue_empty;
   logic                 push;
   logic                 pop;
   bdre_cmd_type         push_cmd;
   bdre_cmd_type         head_cmd;
   logic                 flush_done;
   logic                 ram_wr_en;
   logic [CNT_WIDTH-1:0] ram_wr_addr;
   logic [7:0]           ram_wr_data;
   logic [CNT_WIDTH-1:0] ram_rd_addr;
   logic [7:0]           ram_rd_data;

   // Classifier: compares byte pairs, tracks runs and holds matching bytes.
   bdre_front #(
      .MAX_COMPARE (MAX_COMPARE),
      .ADDR_WIDTH  (ADDR_WIDTH)
   ) u_front (
      .clock                (clock),
      .reset                (reset),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_data             (csr_data),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_original_byte    (req_original_byte),
      .req_modified_byte    (req_modified_byte),
      .req_original_present (req_original_present),
      .req_end_of_stream    (req_end_of_stream),
      .queue_full           (queue_full),
      .push                 (push),
      .push_cmd             (push_cmd),
      .flush_done           (flush_done),
      .ram_wr_en            (ram_wr_en),
      .ram_wr_addr          (ram_wr_addr),
      .ram_wr_data          (ram_wr_data)
   );

   // Pending bytes of the open run.
   bdre_ram #(
      .WIDTH (8),
      .DEPTH (MAX_COMPARE)
   ) u_pending_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Command queue between the two halves.
   bdre_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head     (head_cmd),
      .full     (queue_full),
      .empty    (queue_empty)
   );

   // Emitter: turns commands into rsp beats.
   bdre_back #(
      .MAX_COMPARE (MAX_COMPARE)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_empty        (queue_empty),
      .q_head         (head_cmd),
      .q_pop          (pop),
      .rd_addr        (ram_rd_addr),
      .rd_data        (ram_rd_data),
      .flush_done     (flush_done),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_kind       (rsp_kind),
      .rsp_run_offset (rsp_run_offset),
      .rsp_data_byte  (rsp_data_byte),
      .rsp_last       (rsp_last)
   );

endmodule
`default_nettype wire

FILE: src/bdre_ram.sv
`default_nettype none
module bdre_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Single write port, registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

FILE: src/bdre_front.sv
`default_nettype none
module bdre_front #(
   parameter int MAX_COMPARE = 32,
   parameter int ADDR_WIDTH  = 32,
   localparam int CNT_WIDTH = (MAX_COMPARE > 1) ? $clog2(MAX_COMPARE) : 1
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [bdre_pkg::CSR_WIDTH-1:0] csr_data,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic [7:0]                     req_original_byte,
   input  wire logic [7:0]                     req_modified_byte,
   input  wire logic                           req_original_present,
   input  wire logic                           req_end_of_stream,
   input  wire logic                           queue_full,
   output logic                                push,
   output bdre_pkg::bdre_cmd_type              push_cmd,
   input  wire logic                           flush_done,
   output logic                                ram_wr_en,
   output logic      [CNT_WIDTH-1:0]           ram_wr_addr,
   output logic      [7:0]                     ram_wr_data
);
   import bdre_pkg::*;

   logic [CSR_WIDTH-1:0]  compare_size_ff, compare_size_in;
   logic [ADDR_WIDTH-1:0] addr_ff, addr_in;
   logic                  run_open_ff, run_open_in;
   logic [ADDR_WIDTH-1:0] run_start_ff, run_start_in;
   logic [CNT_WIDTH-1:0]  gap_ff, gap_in;
   logic [CNT_WIDTH-1:0]  pcnt_ff, pcnt_in;
   logic                  flush_pend_ff, flush_pend_in;

   logic                  accept;
   logic                  match;
   logic [8:0]            cs_ext;
   logic [8:0]            eff;
   logic [CNT_WIDTH-1:0]  gap_new;
   logic                  close_first;
   logic                  close_last;

   assign csr_ready = 1'b1;
   assign req_ready = !queue_full && !flush_pend_ff;
   assign accept    = req_valid && req_ready;
   assign match     = req_original_present && (req_original_byte == req_modified_byte);

   // Clamp the compare size to 1..MAX_COMPARE and derive the bridging budget.
   always_comb begin
      cs_ext = 9'(compare_size_ff);
      if (cs_ext == 9'd0) begin
         eff = 9'd1;
      end else if (cs_ext > 9'(MAX_COMPARE)) begin
         eff = 9'(MAX_COMPARE);
      end else begin
         eff = cs_ext;
      end
      gap_new = CNT_WIDTH'(eff - 9'd1);
   end

   // Classify the beat and work out the next state.
   always_comb begin
      compare_size_in = compare_size_ff;
      addr_in         = addr_ff;
      run_open_in     = run_open_ff;
      run_start_in    = run_start_ff;
      gap_in          = gap_ff;
      pcnt_in         = pcnt_ff;
      flush_pend_in   = flush_pend_ff;
      close_first     = 1'b0;
      close_last      = 1'b0;
      ram_wr_en       = 1'b0;
      push            = 1'b0;

      if (csr_valid) begin
         compare_size_in = csr_data;
      end
      if (flush_done) begin
         flush_pend_in = 1'b0;
      end

      if (accept) begin
         if (match) begin
            if (gap_ff == '0) begin
               // Bridging allowance is used up: the run closes here.
               close_first = run_open_ff;
               run_open_in = 1'b0;
               pcnt_in     = '0;
            end else begin
               // Hold the matching byte until the next difference decides.
               ram_wr_en = 1'b1;
               pcnt_in   = pcnt_ff + 1'b1;
               gap_in    = gap_ff - 1'b1;
            end
         end else begin
            gap_in = gap_new;
            if (!run_open_ff) begin
               run_open_in  = 1'b1;
               run_start_in = addr_ff;
            end
            pcnt_in = '0;
            if (pcnt_ff != '0) begin
               flush_pend_in = 1'b1;
            end
         end

         // The address counter saturates at its top value.
         if (addr_ff != {ADDR_WIDTH{1'b1}}) begin
            addr_in = addr_ff + 1'b1;
         end

         if (req_end_of_stream) begin
            close_last   = run_open_in;
            addr_in      = '0;
            run_open_in  = 1'b0;
            run_start_in = '0;
            gap_in       = '0;
            pcnt_in      = '0;
         end

         push = close_first || !match || close_last;
      end
   end

   // Command for the emitter.
   always_comb begin
      push_cmd.close_first = close_first;
      push_cmd.emit_mod    = !match;
      push_cmd.close_last  = close_last;
      push_cmd.flush_cnt   = match ? '0 : PEND_CNT_WIDTH'(pcnt_ff);
      push_cmd.mod_byte    = req_modified_byte;
      push_cmd.run_offset  = (!match && !run_open_ff) ?
                             OFFSET_WIDTH'(addr_ff) : OFFSET_WIDTH'(run_start_ff);
   end

   assign ram_wr_addr = pcnt_ff;
   assign ram_wr_data = req_modified_byte;

   always_ff @(posedge clock) begin
      if (reset) begin
         compare_size_ff <= CSR_WIDTH'(1);
         addr_ff         <= '0;
         run_open_ff     <= 1'b0;
         run_start_ff    <= '0;
         gap_ff          <= '0;
         pcnt_ff         <= '0;
         flush_pend_ff   <= 1'b0;
      end else begin
         compare_size_ff <= compare_size_in;
         addr_ff         <= addr_in;
         run_open_ff     <= run_open_in;
         run_start_ff    <= run_start_in;
         gap_ff          <= gap_in;
         pcnt_ff         <= pcnt_in;
         flush_pend_ff   <= flush_pend_in;
      end
   end

endmodule
`default_nettype wire

FILE: src/bdre_queue.sv
`default_nettype none
module bdre_queue (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   input  wire bdre_pkg::bdre_cmd_type push_cmd,
   input  wire logic                   pop,
   output bdre_pkg::bdre_cmd_type      head,
   output logic                        full,
   output logic                        empty
);
   import bdre_pkg::*;

   bdre_cmd_type slot_ff [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   count_ff, count_in;

   assign full  = (count_ff == 2'd2);
   assign empty = (count_ff == 2'd0);
   assign head  = slot_ff[rd_ptr_ff];

   // Two-entry command queue between classifier and emitter.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = !wr_ptr_ff;
      end
      if (pop) begin
         rd_ptr_in = !rd_ptr_ff;
      end
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
`default_nettype wire

FILE: src/bdre_back.sv
`default_nettype none
module bdre_back #(
   parameter int MAX_COMPARE = 32,
   localparam int CNT_WIDTH = (MAX_COMPARE > 1) ? $clog2(MAX_COMPARE) : 1
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              q_empty,
   input  wire bdre_pkg::bdre_cmd_type            q_head,
   output logic                                   q_pop,
   output logic      [CNT_WIDTH-1:0]              rd_addr,
   input  wire logic [7:0]                        rd_data,
   output logic                                   flush_done,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic                                   rsp_kind,
   output logic      [bdre_pkg::OFFSET_WIDTH-1:0] rsp_run_offset,
   output logic      [7:0]                        rsp_data_byte,
   output logic                                   rsp_last
);
   import bdre_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_CLOSE1 = 3'd1;
   localparam logic [2:0] S_FLUSH  = 3'd2;
   localparam logic [2:0] S_MOD    = 3'd3;
   localparam logic [2:0] S_CLOSE2 = 3'd4;

   logic [2:0]            phase_ff, phase_in;
   bdre_cmd_type          cmd_ff, cmd_in;
   logic [CNT_WIDTH-1:0]  idx_ff, idx_in;

   logic                  valid_ff, valid_in;
   logic                  kind_ff, kind_in;
   logic [OFFSET_WIDTH-1:0] offset_ff;
   logic [7:0]            data_ff, data_in;
   logic                  last_ff, last_in;

   logic                  can_load;
   logic                  load;

   assign can_load = !valid_ff || rsp_ready;

   // Sequencer: one result beat per cycle from the current command while rsp is not stalled.
   always_comb begin
      phase_in   = phase_ff;
      cmd_in     = cmd_ff;
      idx_in     = idx_ff;
      q_pop      = 1'b0;
      flush_done = 1'b0;
      load       = 1'b0;
      kind_in    = KIND_DATA;
      data_in    = 8'd0;
      last_in    = 1'b0;

      case (phase_ff)
         S_IDLE: begin
            if (!q_empty) begin
               q_pop  = 1'b1;
               cmd_in = q_head;
               idx_in = '0;
               if (q_head.close_first) begin
                  phase_in = S_CLOSE1;
               end else if (q_head.flush_cnt != '0) begin
                  phase_in = S_FLUSH;
               end else if (q_head.emit_mod) begin
                  phase_in = S_MOD;
               end else begin
                  phase_in = S_CLOSE2;
               end
            end
         end
         S_CLOSE1: begin
            if (can_load) begin
               load     = 1'b1;
               kind_in  = KIND_CLOSE;
               last_in  = !cmd_ff.close_last;
               phase_in = cmd_ff.close_last ? S_CLOSE2 : S_IDLE;
            end
         end
         S_FLUSH: begin
            if (can_load) begin
               load    = 1'b1;
               data_in = rd_data;
               if (PEND_CNT_WIDTH'(idx_ff) + 1'b1 == cmd_ff.flush_cnt) begin
                  phase_in   = S_MOD;
                  flush_done = 1'b1;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         S_MOD: begin
            if (can_load) begin
               load     = 1'b1;
               data_in  = cmd_ff.mod_byte;
               last_in  = !cmd_ff.close_last;
               phase_in = cmd_ff.close_last ? S_CLOSE2 : S_IDLE;
            end
         end
         S_CLOSE2: begin
            if (can_load) begin
               load     = 1'b1;
               kind_in  = KIND_CLOSE;
               last_in  = 1'b1;
               phase_in = S_IDLE;
            end
         end
         default: begin
            phase_in = S_IDLE;
         end
      endcase

      valid_in = load || (valid_ff && !rsp_ready);
   end

   // The read address follows the next index, so the registered data matches idx_ff.
   assign rd_addr = idx_in;

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      if (load) begin
         kind_ff   <= kind_in;
         offset_ff <= cmd_ff.run_offset;
         data_ff   <= data_in;
         last_ff   <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= S_IDLE;
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_kind       = kind_ff;
   assign rsp_run_offset = offset_ff;
   assign rsp_data_byte  = data_ff;
   assign rsp_last       = last_ff;

endmodule
`default_nettype wire

FILE: tb/sv/testbench.sv
`default_nettype none
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import bdre_pkg::*;

   localparam int MAX_COMPARE     = 32;
   localparam int SETTLE_CYCLES   = 16;
   localparam int CYCLE_LIMIT     = 1000000;
   localparam int PRESSURE_CYCLES = 300;
   localparam int PRINT_LIMIT     = 50;

   // One expected beat on the result channel.
   typedef struct packed {
      logic                    kind;
      logic [OFFSET_WIDTH-1:0] offset;
      logic [7:0]              data;
      logic                    last;
   } run_beat_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_WIDTH-1:0] csr_data = '0;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [7:0]           req_original_byte = '0;
   logic [7:0]           req_modified_byte = '0;
   logic                 req_original_present = 1'b0;
   logic                 req_end_of_stream = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic                 rsp_kind;
   logic [OFFSET_WIDTH-1:0] rsp_run_offset;
   logic [7:0]           rsp_data_byte;
   logic                 rsp_last;

   int unsigned error_count   = 0;
   int unsigned cycle_count   = 0;
   int unsigned rsp_hold_left = 0;
   int unsigned rsp_burst_left = 0;
   bit          idle_enable   = 1'b0;

   // Model of the diff state and the queue of beats it predicts.
   logic [CSR_WIDTH-1:0] model_compare_size = 6'd1;
   logic [31:0]          model_address = '0;
   logic [31:0]          model_run_start = '0;
   bit                   model_run_open = 1'b0;
   int unsigned          model_gap = 0;
   logic [7:0]           model_pending[$];
   run_beat_type         expected_beats[$];

   byte_diff_run_extractor_unit u_top (
      .clock                (clock),
      .reset                (reset),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_data             (csr_data),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_original_byte    (req_original_byte),
      .req_modified_byte    (req_modified_byte),
      .req_original_present (req_original_present),
      .req_end_of_stream    (req_end_of_stream),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_kind             (rsp_kind),
      .rsp_run_offset       (rsp_run_offset),
      .rsp_data_byte        (rsp_data_byte),
      .rsp_last             (rsp_last)
   );

   // Free-running clock, 12 ns period.
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      error_count++;
      if (error_count <= PRINT_LIMIT)
         $display("cycle %0d: %s: got 0x%0h, expected 0x%0h", cycle_count, what, got, want);
   endtask

   function automatic void clear_run_model();
      model_address   = '0;
      model_run_open  = 1'b0;
      model_run_start = '0;
      model_gap       = 0;
      model_pending.delete();
   endfunction

   function automatic void push_run_beat(input logic kind, input logic [7:0] data);
      run_beat_type beat;
      beat.kind   = kind;
      beat.offset = model_run_start;
      beat.data   = data;
      beat.last   = 1'b0;
      expected_beats.push_back(beat);
   endfunction

   // Works out the beats that one byte pair causes and appends them.
   function automatic void predict_byte_pair(input logic [7:0] orig, input logic [7:0] modb,
                                             input logic present, input logic eos);
      int unsigned first_new;
      int unsigned span;
      first_new = expected_beats.size();
      if (present && orig == modb) begin
         // A matching byte either closes the run or is held as a bridge byte.
         if (model_gap == 0) begin
            if (model_run_open) begin
               push_run_beat(KIND_CLOSE, 8'h00);
               model_run_open = 1'b0;
            end
            model_pending.delete();
         end else begin
            if (model_pending.size() < MAX_COMPARE)
               model_pending.push_back(modb);
            model_gap--;
         end
      end else begin
         // A difference refills the bridge budget and releases held bytes.
         span = 32'(model_compare_size);
         if (span < 1)
            span = 1;
         if (span > MAX_COMPARE)
            span = MAX_COMPARE;
         model_gap = span - 1;
         if (!model_run_open) begin
            model_run_open  = 1'b1;
            model_run_start = model_address;
         end
         foreach (model_pending[i])
            push_run_beat(KIND_DATA, model_pending[i]);
         model_pending.delete();
         push_run_beat(KIND_DATA, modb);
      end
      if (model_address != '1)
         model_address = model_address + 1;
      if (eos) begin
         if (model_run_open)
            push_run_beat(KIND_CLOSE, 8'h00);
         clear_run_model();
      end
      if (expected_beats.size() > first_new)
         expected_beats[expected_beats.size() - 1].last = 1'b1;
   endfunction

   // Result side: random stall bursts, plus a long hold when one is requested.
   always @(posedge clock) begin
      if (rsp_hold_left != 0) begin
         rsp_ready <= 1'b0;
         rsp_hold_left = rsp_hold_left - 1;
      end else if (rsp_burst_left != 0) begin
         rsp_ready <= 1'b0;
         rsp_burst_left = rsp_burst_left - 1;
      end else if (idle_enable && $urandom_range(0, 5) == 0) begin
         rsp_ready <= 1'b0;
         rsp_burst_left = $urandom_range(0, 9);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Each accepted result beat is checked against the oldest expectation.
   always @(posedge clock) begin
      run_beat_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_beats.size() == 0) begin
            report_mismatch("beat with nothing expected", 32'(rsp_data_byte), 32'd0);
         end else begin
            want = expected_beats.pop_front();
            if (rsp_kind !== want.kind)
               report_mismatch("kind", 32'(rsp_kind), 32'(want.kind));
            if (rsp_run_offset !== want.offset)
               report_mismatch("run_offset", rsp_run_offset, want.offset);
            if (rsp_data_byte !== want.data)
               report_mismatch("data_byte", 32'(rsp_data_byte), 32'(want.data));
            if (rsp_last !== want.last)
               report_mismatch("last", 32'(rsp_last), 32'(want.last));
         end
      end
   end

   // Offers one byte pair, with an optional idle burst ahead of it.
   task automatic send_byte_pair(input logic [7:0] orig, input logic [7:0] modb,
                                 input logic present, input logic eos);
      int unsigned gap;
      if (idle_enable && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 10);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid            <= 1'b1;
      req_original_byte    <= orig;
      req_modified_byte    <= modb;
      req_original_present <= present;
      req_end_of_stream    <= eos;
      do @(posedge clock); while (!req_ready);
      predict_byte_pair(orig, modb, present, eos);
   endtask

   // Stops offering, waits for every expected beat, then lets the pipeline settle.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_beats.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_compare_size(input logic [CSR_WIDTH-1:0] value);
      drain_results();
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      model_compare_size = value;
   endtask

   // Runs with no bridging: the reset size of one, and a size of zero.
   task automatic test_gap_free_runs();
      write_compare_size(6'd1);
      send_byte_pair(8'h00, 8'h00, 1'b1, 1'b0);
      send_byte_pair(8'h00, 8'hFF, 1'b1, 1'b0);
      send_byte_pair(8'hFF, 8'hFF, 1'b1, 1'b0);
      // Past the end of the original, equal bytes still differ.
      send_byte_pair(8'h5A, 8'h5A, 1'b0, 1'b0);
      send_byte_pair(8'hFF, 8'h00, 1'b1, 1'b0);
      send_byte_pair(8'h80, 8'h80, 1'b1, 1'b1);
      send_byte_pair(8'h01, 8'hFE, 1'b1, 1'b1);
      write_compare_size(6'd0);
      send_byte_pair(8'h7F, 8'h80, 1'b1, 1'b0);
      send_byte_pair(8'h33, 8'h33, 1'b1, 1'b0);
      send_byte_pair(8'h33, 8'h33, 1'b1, 1'b1);
   endtask

   // Matching bytes bridged inside a run, released or dropped.
   task automatic test_bridged_runs();
      write_compare_size(6'd4);
      send_byte_pair(8'h10, 8'h11, 1'b1, 1'b0);
      send_byte_pair(8'h12, 8'h12, 1'b1, 1'b0);
      send_byte_pair(8'h13, 8'h13, 1'b1, 1'b0);
      send_byte_pair(8'h14, 8'hEB, 1'b1, 1'b0);
      repeat (3) send_byte_pair(8'hAA, 8'hAA, 1'b1, 1'b0);
      send_byte_pair(8'hAB, 8'hAB, 1'b1, 1'b0);
      send_byte_pair(8'h00, 8'h99, 1'b0, 1'b0);
      send_byte_pair(8'h42, 8'h42, 1'b1, 1'b0);
      // End of stream with bytes still held: they are dropped.
      send_byte_pair(8'h43, 8'h43, 1'b1, 1'b1);
      send_byte_pair(8'h00, 8'h00, 1'b0, 1'b1);
   endtask

   // A size above the maximum saturates; the full bridge gives the longest burst.
   task automatic test_longest_bridge();
      write_compare_size(6'd63);
      send_byte_pair(8'h01, 8'h02, 1'b1, 1'b0);
      for (int i = 0; i < MAX_COMPARE - 1; i++)
         send_byte_pair(i[7:0], i[7:0], 1'b1, 1'b0);
      send_byte_pair(8'h03, 8'h04, 1'b1, 1'b0);
      send_byte_pair(8'h05, 8'h05, 1'b1, 1'b1);
   endtask

   // The remaining budget survives a size change; the new size applies later.
   task automatic test_size_change_mid_run();
      write_compare_size(6'd8);
      send_byte_pair(8'hC0, 8'h3F, 1'b1, 1'b0);
      send_byte_pair(8'hC1, 8'hC1, 1'b1, 1'b0);
      write_compare_size(6'd2);
      repeat (6) send_byte_pair(8'h77, 8'h77, 1'b1, 1'b0);
      send_byte_pair(8'hC2, 8'h3D, 1'b1, 1'b0);
      send_byte_pair(8'hC3, 8'hC3, 1'b1, 1'b0);
      send_byte_pair(8'hC4, 8'hC4, 1'b1, 1'b0);
      send_byte_pair(8'hC5, 8'h3A, 1'b1, 1'b1);
   endtask

   // Result side held off for a long stretch while byte pairs keep coming.
   task automatic test_backpressure();
      logic [7:0] orig;
      write_compare_size(6'd3);
      idle_enable   = 1'b0;
      rsp_hold_left = PRESSURE_CYCLES;
      for (int i = 0; i < 48; i++) begin
         orig = 8'($urandom);
         send_byte_pair(orig, (i % 3 == 0) ? ~orig : orig, 1'b1, i == 47);
      end
      idle_enable = 1'b1;
   endtask

   // Streams of random content, mostly well formed, with some noise mixed in.
   task automatic test_random_streams(input int unsigned item_target);
      int unsigned sent;
      int unsigned len;
      int unsigned odds;
      int unsigned tail;
      bit          cut;
      logic [7:0]  orig;
      logic [7:0]  modb;
      sent = 0;
      while (sent < item_target) begin
         if ($urandom_range(0, 9) == 0) begin
            send_byte_pair(8'($urandom), 8'($urandom), 1'($urandom_range(0, 1)),
                           $urandom_range(0, 7) == 0);
            sent++;
         end else begin
            len  = $urandom_range(1, 40);
            odds = 1 << $urandom_range(1, 4);
            tail = ($urandom_range(0, 2) == 0) ? $urandom_range(0, len) : 0;
            cut  = $urandom_range(0, 7) == 0;
            for (int i = 0; i < len; i++) begin
               orig = 8'($urandom);
               modb = ($urandom_range(1, odds) == 1) ? 8'($urandom) : orig;
               send_byte_pair(orig, modb, i < len - tail, (i == len - 1) && !cut);
               sent++;
            end
         end
      end
   endtask

   // Test sequence.
   initial begin
      clear_run_model();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      idle_enable = 1'b1;
      test_gap_free_runs();
      test_bridged_runs();
      test_longest_bridge();
      test_size_change_mid_run();
      test_backpressure();
      write_compare_size(6'd2);
      test_random_streams(50);
      write_compare_size(6'd6);
      test_random_streams(50);
      write_compare_size(6'd32);
      test_random_streams(50);
      write_compare_size(6'd17);
      test_random_streams(50);
      // Last part of the run with no idling on either side.
      idle_enable = 1'b0;
      write_compare_size(6'd3);
      test_random_streams(50);
      drain_results();
      if (expected_beats.size() != 0)
         report_mismatch("beats left over", 32'd0, 32'(expected_beats.size()));
      if (error_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
`default_nettype wire

FILE: files.f
src/bdre_pkg.sv
src/bdre_ram.sv
src/bdre_front.sv
src/bdre_queue.sv
src/bdre_back.sv
src/byte_diff_run_extractor_unit.sv
tb/sv/testbench.sv
